FILE: sv/assert_macros.svh
// Assertion macros used by string_to_integer_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/stip_pkg.sv
// Types, character codes and digit decode for the string to integer parser.
package stip_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

  typedef enum logic [4:0] {
    PH_SKIP   = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } digit_t;

  // Digit or letter value, either case; ok low for anything else.
  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c inside {[CH_0:CH_9]}) begin
      d.val = BASE_W'(c - CH_0);
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      d.val = BASE_W'(c - CH_UA + 8'd10);
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      d.val = BASE_W'(c - CH_LA + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

FILE: sv/string_to_integer_parser.sv
// String to integer parser: strtol-style conversion with radix autodetect.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata[7:0] char_code, in_tlast
//  out_    | out | out_tvalid/out_tready| out_tdata[31:0] value (signed)
//  cfg_    | in  | cfg_tvalid/cfg_tready| cfg_tdata[5:0] radix, [7:6] zero
//
// One byte per cycle while in_tready is high. Each request updates the parse state in the
// cycle it is accepted; the one 32x6 multiply-add sits behind the state regs.
// A result appears on out_ the cycle after the byte with in_tlast is taken.
// rst_n is synchronous, active low; the phase returns to PH_SKIP, the rest of the parse state and radix to zero.
// The output register frees the input side: in_tready drops only while a
// result is held and out_tready is low. cfg_tready is always high.
`include "assert_macros.svh"

module string_to_integer_parser
  import stip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input: [7:0] char_code
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // output: [31:0] value
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // config: [5:0] radix, [7:6] unused
  input  logic [7:0]  cfg_tdata,
  input  logic        cfg_tvalid,
  output logic        cfg_tready
);

  // Parse state
  phase_t              phase_r, phase_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic                neg_r, neg_nxt;
  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic [BASE_W-1:0]   radix_r;

  // Output register; the sign is applied on the way out
  logic                out_tvalid_r;
  logic [VALUE_W-1:0]  out_val_r;
  logic                out_neg_r;

  logic                in_acc;
  logic                load_out;
  digit_t              dig;
  logic [VALUE_W-1:0]  mac;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign load_out   = in_acc && in_tlast;
  assign cfg_tready = 1'b1;

  assign dig = digit_of(in_tdata);
  // acc_r is zero until the first digit, so base_r need not be final before then.
  assign mac = VALUE_W'(acc_r * VALUE_W'(base_r)) + VALUE_W'(dig.val);

  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    case (phase_r)
      PH_SKIP, PH_FIRST: begin
        if (phase_r == PH_SKIP && (in_tdata == CH_SPACE || in_tdata == CH_TAB)) begin
          phase_nxt = PH_SKIP;
        end else if (phase_r == PH_SKIP && in_tdata == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_FIRST;
        end else if (phase_r == PH_SKIP && in_tdata == CH_PLUS) begin
          phase_nxt = PH_FIRST;
        end else if (radix_r != '0) begin
          // fixed radix: take the byte as a digit
          base_nxt = radix_r;
          if (dig.ok) begin
            acc_nxt   = mac;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end else if (!dig.ok) begin
          phase_nxt = PH_DONE;
        end else if (dig.val == '0) begin
          // leading zero: octal unless an x follows
          base_nxt  = BASE_OCT;
          phase_nxt = PH_ZERO;
        end else begin
          base_nxt  = (dig.val < BASE_DEC) ? BASE_DEC : dig.val;
          acc_nxt   = mac;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_ZERO: begin
        if (in_tdata == CH_LX || in_tdata == CH_UX) begin
          base_nxt  = BASE_HEX;
          phase_nxt = PH_DIGITS;
        end else if (dig.ok) begin
          acc_nxt   = mac;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (dig.ok) begin
          acc_nxt = mac;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      base_r  <= '0;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      radix_r <= '0;
    end else begin
      if (cfg_tvalid && cfg_tready) begin
        radix_r <= cfg_tdata[BASE_W-1:0];
      end
      if (in_acc) begin
        if (in_tlast) begin
          // end of string: back to the start for the next one
          phase_r <= PH_SKIP;
          base_r  <= '0;
          neg_r   <= 1'b0;
          acc_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          base_r  <= base_nxt;
          neg_r   <= neg_nxt;
          acc_r   <= acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_val_r <= acc_nxt;
      out_neg_r <= neg_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_neg_r ? (VALUE_W'(0) - out_val_r) : out_val_r;

  // Checks
  `ASSERT_NEXT(a_last_gives_result, in_tvalid && in_tready && in_tlast, out_tvalid,
               "last byte taken but no result pending")
  `ASSERT_NEXT(a_last_clears_state, in_tvalid && in_tready && in_tlast,
               phase_r == PH_SKIP && acc_r == '0 && !neg_r,
               "parse state not cleared after end of string")
  `ASSERT_NOW(a_acc_zero_before_digits,
              phase_r == PH_SKIP || phase_r == PH_FIRST || phase_r == PH_ZERO,
              acc_r == '0, "accumulator nonzero before first digit")
  `ASSERT_NOW(a_zero_is_octal, phase_r == PH_ZERO, base_r == BASE_OCT,
              "leading-zero phase without octal base")

endmodule
